[hw/rtl/fswf_pkg.sv]
// fswf_pkg: shared widths, mode codes, payload and stage types for the
// five-sample window filter; depends on nothing else
`timescale 1ns / 1ps

package fswf_pkg;

    // field widths (Q23.8 values, unsigned timestamps)
    localparam int VALUE_WIDTH = 32;
    localparam int TIME_WIDTH  = 31;

    // window geometry
    localparam int TAPS        = 5;
    localparam int CENTER      = 2;
    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = $clog2(TAPS + 1);

    // deviation 5*x - S and window sum both fit in this signed width
    localparam int DEV_W    = VALUE_WIDTH + 3;
    localparam int SPLIT_LO = (DEV_W + 1) / 2;
    localparam int SPLIT_HI = DEV_W - SPLIT_LO;
    localparam int SQ_W     = 2 * DEV_W + 2;
    localparam int PROD_W   = 2 * DEV_W;

    // mean: |S| / 5 as |S| * ceil(2^MEAN_SHIFT / 5) >> MEAN_SHIFT, exact for all sums
    localparam int MEAN_SHIFT = VALUE_WIDTH + 5;
    localparam logic [MEAN_SHIFT:0] MEAN_POW = {1'b1, {MEAN_SHIFT{1'b0}}};
    localparam logic [MEAN_SHIFT:0] MEAN_RECIP_FULL =
        (MEAN_POW + (MEAN_SHIFT + 1)'(TAPS - 1)) / (MEAN_SHIFT + 1)'(TAPS);
    localparam logic [DEV_W-1:0]    MEAN_RECIP = MEAN_RECIP_FULL[DEV_W-1:0];
    localparam logic [SPLIT_LO-1:0] RECIP_LO   = MEAN_RECIP[SPLIT_LO-1:0];
    localparam logic [SPLIT_HI-1:0] RECIP_HI   = MEAN_RECIP[DEV_W-1:SPLIT_LO];

    // filter mode codes
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_OUTLIER = 2'd0;
    localparam mode_t MODE_MEDIAN  = 2'd1;
    localparam mode_t MODE_MEAN    = 2'd2;

    typedef logic [TIME_WIDTH-1:0]         stamp_t;
    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    typedef struct packed {
        stamp_t sample_time;
        value_t sample_value;
        logic   end_of_stream;
    } in_item_t;

    typedef struct packed {
        stamp_t out_time;
        value_t out_value;
        logic   run_last;
    } out_item_t;

    // per-item context carried down the pipeline
    typedef struct packed {
        logic [CNT_W-1:0] seen;
        logic             eos;
        mode_t            mode;
        stamp_t           t_center;
        stamp_t           t_prev;
        stamp_t           t_new;
        value_t           v_center;
        value_t           v_prev;
        value_t           v_new;
        value_t           med;
    } ctx_t;

    // window snapshot handed from the window register to the arithmetic
    typedef struct packed {
        value_t [TAPS-1:0] vals;
        ctx_t              ctx;
    } win_item_t;

    // arithmetic results handed to the result stage
    typedef struct packed {
        ctx_t            ctx;
        logic [SQ_W-1:0] dev_total;
        logic [SQ_W-1:0] dev_center;
        value_t          mean;
    } stats_t;

endpackage

[hw/rtl/fswf_window.sv]
// fswf_window: sliding window taps, sample count and the input register
// that feeds the arithmetic pipeline; depends on fswf_pkg
`timescale 1ns / 1ps

module fswf_window (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fswf_pkg::in_item_t  s_data,
    input  fswf_pkg::mode_t     filter_mode,
    output logic                win_valid,
    input  logic                win_ready,
    output fswf_pkg::win_item_t win_data
);
    import fswf_pkg::*;

    // only the center tap and newer ever report a timestamp
    localparam int KEEP_T = TAPS - CENTER;

    value_t           tap_value_reg [TAPS];
    stamp_t           tap_time_reg  [KEEP_T];
    value_t           value_next    [TAPS];
    stamp_t           time_next     [KEEP_T];
    logic [CNT_W-1:0] seen_reg;
    logic [CNT_W-1:0] seen_next;
    logic             out_valid_reg;
    win_item_t        out_data_reg;
    win_item_t        out_data_next;
    logic             take;

    // input register frees up when empty or drained downstream
    assign s_ready = !out_valid_reg || win_ready;
    assign take    = s_valid && s_ready;

    // shift the new sample in at the newest tap
    always_comb begin
        for (int i = 0; i < TAPS - 1; i++) begin
            value_next[i] = tap_value_reg[i + 1];
        end
        value_next[TAPS - 1] = s_data.sample_value;
        for (int i = 0; i < KEEP_T - 1; i++) begin
            time_next[i] = tap_time_reg[i + 1];
        end
        time_next[KEEP_T - 1] = s_data.sample_time;
    end

    // count saturates at a full window
    assign seen_next = (seen_reg == CNT_W'(TAPS)) ? seen_reg : seen_reg + 1'b1;

    // snapshot of the shifted window for the pipeline
    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            out_data_next.vals[i] = value_next[i];
        end
        out_data_next.ctx.seen     = seen_next;
        out_data_next.ctx.eos      = s_data.end_of_stream;
        out_data_next.ctx.mode     = filter_mode;
        out_data_next.ctx.t_center = time_next[0];
        out_data_next.ctx.t_prev   = time_next[KEEP_T - 2];
        out_data_next.ctx.t_new    = time_next[KEEP_T - 1];
        out_data_next.ctx.v_center = value_next[CENTER];
        out_data_next.ctx.v_prev   = value_next[TAPS - 2];
        out_data_next.ctx.v_new    = value_next[TAPS - 1];
        out_data_next.ctx.med      = '0;
    end

    // control: count restarts after end of stream
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                seen_reg <= s_data.end_of_stream ? '0 : seen_next;
            end
            if (take) begin
                out_valid_reg <= 1'b1;
            end else if (win_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // taps and input register; taps are not reset, so stale taps are read until overwritten
    always_ff @(posedge aclk) begin
        if (take) begin
            tap_value_reg <= value_next;
            tap_time_reg  <= time_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign win_valid = out_valid_reg;
    assign win_data  = out_data_reg;

`ifndef SYNTHESIS
    a_seen_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= CNT_W'(TAPS))
        else $error("sample count above window depth");

    a_eos_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.end_of_stream) |=> (seen_reg == '0))
        else $error("window count not restarted after end of stream");
`endif

endmodule

[hw/rtl/fswf_stats.sv]
// fswf_stats: five-stage arithmetic pipeline (sum and median, deviations,
// split products, squares and mean, totals); depends on fswf_pkg
`timescale 1ns / 1ps

module fswf_stats (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  fswf_pkg::win_item_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fswf_pkg::stats_t    out_data
);
    import fswf_pkg::*;

    localparam int RANK_W = $clog2(TAPS);

    // stage ready chain, bubbles collapse
    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;

    // stage 1: window sum and median
    value_t                   s1_vals_reg [TAPS];
    logic signed [DEV_W-1:0]  s1_sum_reg;
    ctx_t                     s1_ctx_reg;
    logic signed [DEV_W-1:0]  sum_next;
    value_t                   med_next;
    ctx_t                     s1_ctx_next;

    // stage 2: deviations and sum magnitude
    logic signed [DEV_W-1:0]  s2_dev_reg [TAPS];
    logic [DEV_W-1:0]         s2_mag_reg;
    logic                     s2_neg_reg;
    ctx_t                     s2_ctx_reg;
    logic signed [DEV_W-1:0]  dev_next [TAPS];
    logic [DEV_W-1:0]         mag_next;

    // stage 3: partial products
    logic signed [2*SPLIT_HI-1:0]       s3_hh_reg [TAPS];
    logic signed [SPLIT_HI+SPLIT_LO:0]  s3_hl_reg [TAPS];
    logic [2*SPLIT_LO-1:0]              s3_ll_reg [TAPS];
    logic signed [2*SPLIT_HI-1:0]       hh_next [TAPS];
    logic signed [SPLIT_HI+SPLIT_LO:0]  hl_next [TAPS];
    logic [2*SPLIT_LO-1:0]              ll_next [TAPS];
    logic [2*SPLIT_LO-1:0]              s3_mll_reg;
    logic [SPLIT_LO+SPLIT_HI-1:0]       s3_mlh_reg;
    logic [SPLIT_LO+SPLIT_HI-1:0]       s3_mhl_reg;
    logic [2*SPLIT_HI-1:0]              s3_mhh_reg;
    logic                               s3_neg_reg;
    ctx_t                               s3_ctx_reg;

    // stage 4: squares and mean product
    logic [SQ_W-1:0]   s4_sq_reg [TAPS];
    logic [SQ_W-1:0]   sq_next [TAPS];
    logic [PROD_W-1:0] s4_mprod_reg;
    logic [PROD_W-1:0] mprod_next;
    logic              s4_neg_reg;
    ctx_t              s4_ctx_reg;

    // stage 5: totals and signed mean
    stats_t                  s5_data_reg;
    logic [SQ_W-1:0]         total_next;
    logic [VALUE_WIDTH-1:0]  quot;

    assign s5_rdy   = !s5_valid_reg || out_ready;
    assign s4_rdy   = !s4_valid_reg || s5_rdy;
    assign s3_rdy   = !s3_valid_reg || s4_rdy;
    assign s2_rdy   = !s2_valid_reg || s3_rdy;
    assign s1_rdy   = !s1_valid_reg || s2_rdy;
    assign in_ready = s1_rdy;

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            if (s1_rdy) s1_valid_reg <= in_valid;
            if (s2_rdy) s2_valid_reg <= s1_valid_reg;
            if (s3_rdy) s3_valid_reg <= s2_valid_reg;
            if (s4_rdy) s4_valid_reg <= s3_valid_reg;
            if (s5_rdy) s5_valid_reg <= s4_valid_reg;
        end
    end

    // window sum
    always_comb begin
        sum_next = '0;
        for (int i = 0; i < TAPS; i++) begin
            sum_next = sum_next + DEV_W'($signed(in_data.vals[i]));
        end
    end

    // median: the tap with exactly CENTER taps ranked above it
    always_comb begin
        logic [RANK_W-1:0] rank;
        med_next = '0;
        for (int i = 0; i < TAPS; i++) begin
            rank = '0;
            for (int j = 0; j < TAPS; j++) begin
                if (j != i) begin
                    if (($signed(in_data.vals[j]) > $signed(in_data.vals[i])) ||
                        (($signed(in_data.vals[j]) == $signed(in_data.vals[i])) && (j < i))) begin
                        rank = rank + 1'b1;
                    end
                end
            end
            if (rank == RANK_W'(CENTER)) begin
                med_next = med_next | $signed(in_data.vals[i]);
            end
        end
    end

    always_comb begin
        s1_ctx_next     = in_data.ctx;
        s1_ctx_next.med = med_next;
    end

    always_ff @(posedge aclk) begin
        if (s1_rdy) begin
            for (int i = 0; i < TAPS; i++) begin
                s1_vals_reg[i] <= $signed(in_data.vals[i]);
            end
            s1_sum_reg <= sum_next;
            s1_ctx_reg <= s1_ctx_next;
        end
    end

    // deviation d = 5*x - S per tap, magnitude of S for the mean
    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            dev_next[i] = (DEV_W'(s1_vals_reg[i]) <<< 2) + DEV_W'(s1_vals_reg[i]) - s1_sum_reg;
        end
        mag_next = s1_sum_reg[DEV_W-1] ? DEV_W'(-s1_sum_reg) : DEV_W'(s1_sum_reg);
    end

    always_ff @(posedge aclk) begin
        if (s2_rdy) begin
            s2_dev_reg <= dev_next;
            s2_mag_reg <= mag_next;
            s2_neg_reg <= s1_sum_reg[DEV_W-1];
            s2_ctx_reg <= s1_ctx_reg;
        end
    end

    // half-width products: signed high part, unsigned low part
    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            hh_next[i] = $signed(s2_dev_reg[i][DEV_W-1:SPLIT_LO]) *
                         $signed(s2_dev_reg[i][DEV_W-1:SPLIT_LO]);
            hl_next[i] = $signed(s2_dev_reg[i][DEV_W-1:SPLIT_LO]) *
                         $signed({1'b0, s2_dev_reg[i][SPLIT_LO-1:0]});
            ll_next[i] = s2_dev_reg[i][SPLIT_LO-1:0] * s2_dev_reg[i][SPLIT_LO-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_rdy) begin
            s3_hh_reg  <= hh_next;
            s3_hl_reg  <= hl_next;
            s3_ll_reg  <= ll_next;
            s3_mll_reg <= s2_mag_reg[SPLIT_LO-1:0] * RECIP_LO;
            s3_mlh_reg <= s2_mag_reg[SPLIT_LO-1:0] * RECIP_HI;
            s3_mhl_reg <= s2_mag_reg[DEV_W-1:SPLIT_LO] * RECIP_LO;
            s3_mhh_reg <= s2_mag_reg[DEV_W-1:SPLIT_LO] * RECIP_HI;
            s3_neg_reg <= s2_neg_reg;
            s3_ctx_reg <= s2_ctx_reg;
        end
    end

    // recombine: d^2 = hh<<2L + 2*hl<<L + ll
    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            sq_next[i] = (SQ_W'(s3_hh_reg[i]) << (2 * SPLIT_LO)) +
                         (SQ_W'(s3_hl_reg[i]) << (SPLIT_LO + 1)) +
                         SQ_W'(s3_ll_reg[i]);
        end
        mprod_next = (PROD_W'(s3_mhh_reg) << (2 * SPLIT_LO)) +
                     ((PROD_W'(s3_mlh_reg) + PROD_W'(s3_mhl_reg)) << SPLIT_LO) +
                     PROD_W'(s3_mll_reg);
    end

    always_ff @(posedge aclk) begin
        if (s4_rdy) begin
            s4_sq_reg    <= sq_next;
            s4_mprod_reg <= mprod_next;
            s4_neg_reg   <= s3_neg_reg;
            s4_ctx_reg   <= s3_ctx_reg;
        end
    end

    // sum of squared deviations, center term times five, signed mean
    always_comb begin
        total_next = '0;
        for (int i = 0; i < TAPS; i++) begin
            total_next = total_next + s4_sq_reg[i];
        end
        quot = s4_mprod_reg[MEAN_SHIFT +: VALUE_WIDTH];
    end

    always_ff @(posedge aclk) begin
        if (s5_rdy) begin
            s5_data_reg.ctx        <= s4_ctx_reg;
            s5_data_reg.dev_total  <= total_next;
            s5_data_reg.dev_center <= (s4_sq_reg[CENTER] << 2) + s4_sq_reg[CENTER];
            s5_data_reg.mean       <= s4_neg_reg ? -quot : quot;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_data  = s5_data_reg;

endmodule

[hw/rtl/fswf_result.sv]
// fswf_result: picks the results of one item into three slots and hands
// them out one transfer at a time; depends on fswf_pkg
`timescale 1ns / 1ps

module fswf_result (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  fswf_pkg::stats_t    in_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fswf_pkg::out_item_t m_data
);
    import fswf_pkg::*;

    // slot order is emission order
    localparam int SLOT_CENTER = 0;
    localparam int SLOT_PREV   = 1;
    localparam int SLOT_NEW    = 2;
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    stamp_t                 slot_time_reg  [MAX_RESULTS];
    value_t                 slot_value_reg [MAX_RESULTS];
    stamp_t                 slot_time_next  [MAX_RESULTS];
    value_t                 slot_value_next [MAX_RESULTS];
    logic [MAX_RESULTS-1:0] pend_reg;
    logic [MAX_RESULTS-1:0] pend_next;
    logic [MAX_RESULTS-1:0] pend_rest;
    logic [IDX_W-1:0]       cur_idx;
    logic                   is_last;
    logic                   full;
    logic                   mode_out;
    logic                   drop;
    value_t                 center_value;

    // which results this item produces
    always_comb begin
        full     = (in_data.ctx.seen == CNT_W'(TAPS));
        mode_out = (in_data.ctx.mode == MODE_OUTLIER);
        drop     = (in_data.dev_center > in_data.dev_total);
        pend_next[SLOT_CENTER] = full && ((mode_out && !drop) ||
                                          (in_data.ctx.mode == MODE_MEDIAN) ||
                                          (in_data.ctx.mode == MODE_MEAN));
        pend_next[SLOT_PREV]   = mode_out && in_data.ctx.eos &&
                                 (in_data.ctx.seen >= CNT_W'(TAPS - 1));
        pend_next[SLOT_NEW]    = mode_out &&
                                 ((in_data.ctx.seen <= CNT_W'(CENTER)) || in_data.ctx.eos);
    end

    // value reported at the center time
    always_comb begin
        case (in_data.ctx.mode)
            MODE_MEDIAN: center_value = in_data.ctx.med;
            MODE_MEAN:   center_value = in_data.mean;
            default:     center_value = in_data.ctx.v_center;
        endcase
        slot_time_next[SLOT_CENTER]  = in_data.ctx.t_center;
        slot_value_next[SLOT_CENTER] = center_value;
        slot_time_next[SLOT_PREV]    = in_data.ctx.t_prev;
        slot_value_next[SLOT_PREV]   = in_data.ctx.v_prev;
        slot_time_next[SLOT_NEW]     = in_data.ctx.t_new;
        slot_value_next[SLOT_NEW]    = in_data.ctx.v_new;
    end

    // lowest pending slot goes out first
    always_comb begin
        cur_idx = IDX_W'(MAX_RESULTS - 1);
        for (int i = MAX_RESULTS - 1; i >= 0; i--) begin
            if (pend_reg[i]) cur_idx = IDX_W'(i);
        end
    end

    assign pend_rest = pend_reg & (pend_reg - 1'b1);
    assign is_last   = (pend_rest == '0);
    assign m_valid   = |pend_reg;
    assign in_ready  = !m_valid || (m_ready && is_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else if (in_valid && in_ready) begin
            pend_reg <= pend_next;
        end else if (m_valid && m_ready) begin
            pend_reg <= pend_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            slot_time_reg  <= slot_time_next;
            slot_value_reg <= slot_value_next;
        end
    end

    assign m_data.out_time  = slot_time_reg[cur_idx];
    assign m_data.out_value = slot_value_reg[cur_idx];
    assign m_data.run_last  = is_last;

`ifndef SYNTHESIS
    a_prev_with_new: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg[SLOT_PREV] |-> pend_reg[SLOT_NEW])
        else $error("tail flush lost its newest sample");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.run_last) |=> m_valid)
        else $error("result run ended without a last marker");
`endif

endmodule

[hw/rtl/five_sample_window_filter.sv]
// five_sample_window_filter top level: filter_mode register, window, pipeline, result stage.
// Depends on fswf_pkg, fswf_window, fswf_stats and fswf_result.
// Each item is registered in the window, each fswf_stats stage, then the result slots.
// Throughput: one input per cycle while m_ready is high, set by the single result port;
// an item with k results (k up to 3 at end of stream in outlier mode) takes k transfers.
// Reset (aresetn low, synchronous): filter_mode to outlier rejection, window empty, stages empty.
`timescale 1ns / 1ps

module five_sample_window_filter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fswf_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fswf_pkg::out_item_t m_data,
    input  logic                cfg_wr_en,
    input  fswf_pkg::mode_t     cfg_wr_data
);
    import fswf_pkg::*;

    mode_t     filter_mode_reg;
    logic      win_valid;
    logic      win_ready;
    win_item_t win_data;
    logic      st_valid;
    logic      st_ready;
    stats_t    st_data;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_mode_reg <= MODE_OUTLIER;
        end else if (cfg_wr_en) begin
            filter_mode_reg <= cfg_wr_data;
        end
    end

    // window taps and input register
    fswf_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .filter_mode (filter_mode_reg),
        .win_valid   (win_valid),
        .win_ready   (win_ready),
        .win_data    (win_data)
    );

    // sum, median, deviation squares and mean
    fswf_stats u_stats (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (win_valid),
        .in_ready  (win_ready),
        .in_data   (win_data),
        .out_valid (st_valid),
        .out_ready (st_ready),
        .out_data  (st_data)
    );

    // result selection and output register
    fswf_result u_result (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (st_valid),
        .in_ready (st_ready),
        .in_data  (st_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
